/* rtl/lrci_pkg.sv */
// shared types, constants and helpers for the line rasterizer with color interpolation
`default_nettype none

package lrci_pkg;

	// field widths
	localparam int COORD_BITS     = 13;
	localparam int COLOR_BITS     = 8;
	localparam int CANVAS_BITS    = 13;
	localparam int PIX_BITS       = 12;
	localparam int OUT_COLOR_BITS = 8;
	localparam int NUM_CHAN       = 3;

	// derived widths
	localparam int ERR_W      = COORD_BITS + 3;
	localparam int CMP_W      = (COORD_BITS > CANVAS_BITS) ? COORD_BITS : CANVAS_BITS;
	localparam int DIV_CNT_W  = $clog2(COLOR_BITS);
	localparam int MAX_RESULTS = 64;
	localparam int CNT_W      = $clog2(MAX_RESULTS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W  = 1;

	// color channel slots
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CANVAS_WIDTH  = 1'd0,
		REG_CANVAS_HEIGHT = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [CANVAS_BITS-1:0] width;
		logic [CANVAS_BITS-1:0] height;
	} canvas_t;

	// one classified line, as it travels from front to walker
	typedef struct packed {
		logic [COORD_BITS-1:0]                    x0;
		logic [COORD_BITS-1:0]                    y0;
		logic                                     x_major;
		logic                                     neg_x;
		logic                                     neg_y;
		logic [COORD_BITS-1:0]                    span;
		logic [ERR_W-1:0]                         two_minor;
		logic [ERR_W-1:0]                         two_diff;
		logic [ERR_W-1:0]                         err_init;
		logic [NUM_CHAN-1:0][COLOR_BITS-1:0]      col_start;
		logic [NUM_CHAN-1:0]                      col_neg;
		logic [NUM_CHAN-1:0][COLOR_BITS-1:0]      inc_q;
		logic [NUM_CHAN-1:0][COORD_BITS-1:0]      inc_r;
	} line_t;

	// one emitted pixel
	typedef struct packed {
		logic [PIX_BITS-1:0]                        x;
		logic [PIX_BITS-1:0]                        y;
		logic [NUM_CHAN-1:0][OUT_COLOR_BITS-1:0]    color;
		logic                                       last;
	} pixel_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_WALK,
		B_FLUSH
	} walk_state_t;

	// start color moved by the accumulated quotient toward the end color
	function automatic logic [COLOR_BITS-1:0] color_at(
		input logic [COLOR_BITS-1:0] base,
		input logic                  neg,
		input logic [COLOR_BITS-1:0] delta
	);
		return neg ? (base - delta) : (base + delta);
	endfunction

endpackage

`default_nettype wire

/* rtl/line_rasterizer_color_interp.sv */
// top level of the line rasterizer with per-pixel color interpolation
//
//  channel  direction  handshake              payload
//  in       to block   in_valid / in_stall    start_x..end_y, start_* and end_* colors
//  out      from block out_valid / out_stall  pixel_x, pixel_y, pixel_*, last_pixel
//  cfg      to block   cfg_write              cfg_index, cfg_data
//
// setup accepts a line, runs the color step divider over COLOR_BITS quotient bits,
// then hands the line to the two-entry queue, waiting while the queue is full.
// the walker loads a line, then steps one visited pixel per cycle unless held by out_stall
// (major span + 1, clipped pixels included, fewer when the 64-result cap stops it),
// then releases the final held pixel.
// reset clears all control state; canvas size resets to 640 by 480.
// out_stall holds the walker when a kept pixel finds the output register busy, and holds the final flush.
`default_nettype none

module line_rasterizer_color_interp import lrci_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CANVAS_BITS-1:0] cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [COORD_BITS-1:0]  start_x,
	input  wire logic [COORD_BITS-1:0]  start_y,
	input  wire logic [COORD_BITS-1:0]  end_x,
	input  wire logic [COORD_BITS-1:0]  end_y,
	input  wire logic [COLOR_BITS-1:0]  start_red,
	input  wire logic [COLOR_BITS-1:0]  start_green,
	input  wire logic [COLOR_BITS-1:0]  start_blue,
	input  wire logic [COLOR_BITS-1:0]  end_red,
	input  wire logic [COLOR_BITS-1:0]  end_green,
	input  wire logic [COLOR_BITS-1:0]  end_blue,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [PIX_BITS-1:0]         pixel_x,
	output logic [PIX_BITS-1:0]         pixel_y,
	output logic [OUT_COLOR_BITS-1:0]   pixel_red,
	output logic [OUT_COLOR_BITS-1:0]   pixel_green,
	output logic [OUT_COLOR_BITS-1:0]   pixel_blue,
	output logic                        last_pixel
);

	canvas_t canvas_q;
	logic push_valid, queue_full, queue_empty, pop;
	line_t push_data, pop_data;
	pixel_t out_pixel;

	// canvas size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_q.width  <= CANVAS_BITS'(640);
			canvas_q.height <= CANVAS_BITS'(480);
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CANVAS_WIDTH:  canvas_q.width  <= cfg_data;
				REG_CANVAS_HEIGHT: canvas_q.height <= cfg_data;
			endcase
		end
	end

	// line setup
	lrci_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.start_red   (start_red),
		.start_green (start_green),
		.start_blue  (start_blue),
		.end_red     (end_red),
		.end_green   (end_green),
		.end_blue    (end_blue),
		.push_valid  (push_valid),
		.push_data   (push_data),
		.queue_full  (queue_full)
	);

	// decoupling queue
	lrci_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (queue_full),
		.pop        (pop),
		.pop_data   (pop_data),
		.empty      (queue_empty)
	);

	// pixel walker
	lrci_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.canvas      (canvas_q),
		.queue_empty (queue_empty),
		.queue_data  (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_pixel   (out_pixel)
	);

	// result fields
	always_comb begin
		pixel_x     = out_pixel.x;
		pixel_y     = out_pixel.y;
		pixel_red   = out_pixel.color[CH_RED];
		pixel_green = out_pixel.color[CH_GREEN];
		pixel_blue  = out_pixel.color[CH_BLUE];
		last_pixel  = out_pixel.last;
	end

endmodule

`default_nettype wire

/* rtl/lrci_front.sv */
// line setup front end: deltas, major axis, error terms and per-channel color step division
`default_nettype none

module lrci_front import lrci_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	input  wire logic [COLOR_BITS-1:0] start_red,
	input  wire logic [COLOR_BITS-1:0] start_green,
	input  wire logic [COLOR_BITS-1:0] start_blue,
	input  wire logic [COLOR_BITS-1:0] end_red,
	input  wire logic [COLOR_BITS-1:0] end_green,
	input  wire logic [COLOR_BITS-1:0] end_blue,
	output logic                       push_valid,
	output line_t                      push_data,
	input  wire logic                  queue_full
);

	front_state_t state_q, state_nxt;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	line_t line_q;
	line_t setup;
	logic accept;

	logic signed [COORD_BITS:0] dxs, dys, adx, ady;
	logic [COORD_BITS-1:0] dx, dy, major, minor;
	logic [NUM_CHAN-1:0][COLOR_BITS-1:0] cs, ce;

	logic [NUM_CHAN-1:0][COORD_BITS:0] div_t;
	logic [NUM_CHAN-1:0]               div_ge;
	logic [NUM_CHAN-1:0][COORD_BITS:0] div_sub;

	// classify the incoming line
	always_comb begin
		cs[CH_RED]   = start_red;
		cs[CH_GREEN] = start_green;
		cs[CH_BLUE]  = start_blue;
		ce[CH_RED]   = end_red;
		ce[CH_GREEN] = end_green;
		ce[CH_BLUE]  = end_blue;

		dxs = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
		dys = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
		adx = dxs[COORD_BITS] ? -dxs : dxs;
		ady = dys[COORD_BITS] ? -dys : dys;
		dx  = adx[COORD_BITS-1:0];
		dy  = ady[COORD_BITS-1:0];

		setup.x0      = start_x;
		setup.y0      = start_y;
		setup.neg_x   = dxs[COORD_BITS];
		setup.neg_y   = dys[COORD_BITS];
		setup.x_major = (dy <= dx);
		major = setup.x_major ? dx : dy;
		minor = setup.x_major ? dy : dx;
		setup.span      = major;
		setup.two_minor = ERR_W'({minor, 1'b0});
		setup.two_diff  = ERR_W'({minor, 1'b0}) - ERR_W'({major, 1'b0});
		setup.err_init  = ERR_W'({minor, 1'b0}) - ERR_W'(major);

		// the divider works on magnitudes; the remainder starts at zero
		for (int c = 0; c < NUM_CHAN; c++) begin
			setup.col_start[c] = cs[c];
			setup.col_neg[c]   = (ce[c] < cs[c]);
			setup.inc_q[c]     = (ce[c] < cs[c]) ? (cs[c] - ce[c]) : (ce[c] - cs[c]);
			setup.inc_r[c]     = '0;
		end
	end

	// one restoring division step per cycle, all channels side by side
	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			div_t[c]   = {line_q.inc_r[c], line_q.inc_q[c][COLOR_BITS-1]};
			div_ge[c]  = (div_t[c] >= {1'b0, line_q.span});
			div_sub[c] = div_t[c] - {1'b0, line_q.span};
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (in_valid) state_nxt = F_DIV;
			end
			F_DIV: begin
				if (div_cnt_q == '0) state_nxt = F_PUSH;
			end
			F_PUSH: begin
				if (!queue_full) state_nxt = F_IDLE;
			end
			default: state_nxt = F_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall   = (state_q != F_IDLE);
		accept     = (state_q == F_IDLE) && in_valid;
		push_valid = (state_q == F_PUSH);
		push_data  = line_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) div_cnt_q <= DIV_CNT_W'(COLOR_BITS - 1);
			else if (state_q == F_DIV) div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// line record, with quotient and remainder built in place
	always_ff @(posedge clk) begin
		if (accept) begin
			line_q <= setup;
		end else if (state_q == F_DIV) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				line_q.inc_q[c] <= {line_q.inc_q[c][COLOR_BITS-2:0], div_ge[c]};
				line_q.inc_r[c] <= div_ge[c] ? div_sub[c][COORD_BITS-1:0]
					: div_t[c][COORD_BITS-1:0];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/lrci_queue.sv */
// short register queue of classified lines between setup and walker
`default_nettype none

module lrci_queue import lrci_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	input  wire line_t push_data,
	output logic       full,
	input  wire logic  pop,
	output line_t      pop_data,
	output logic       empty
);

	line_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push, do_pop;

	always_comb begin
		full     = (count_q == QCNT_W'(QUEUE_DEPTH));
		empty    = (count_q == '0);
		do_push  = push_valid && !full;
		do_pop   = pop && !empty;
		pop_data = entry_q[rd_ptr_q];
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

/* rtl/lrci_walk.sv */
// Bresenham walker: one pixel a cycle unless stalled; clips, interpolates color, holds one pixel back
`default_nettype none

module lrci_walk import lrci_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire canvas_t canvas,
	input  wire logic    queue_empty,
	input  wire line_t   queue_data,
	output logic         pop,
	output logic         out_valid,
	input  wire logic    out_stall,
	output pixel_t       out_pixel
);

	walk_state_t state_q, state_nxt;
	line_t line_q;
	logic [COORD_BITS-1:0] walk_x_q, walk_y_q, steps_q;
	logic [ERR_W-1:0] err_q;
	logic [NUM_CHAN-1:0][COLOR_BITS-1:0] acc_q;
	logic [NUM_CHAN-1:0][COORD_BITS-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic pend_v_q;
	pixel_t pend_q;
	logic out_valid_q;
	pixel_t out_q;

	logic room, on_canvas, hold, go, take_pix, out_load, walk_end, advance, err_pos;
	pixel_t cur;
	logic [NUM_CHAN-1:0][COORD_BITS:0] rsum;
	logic [NUM_CHAN-1:0]               rwrap;

	// current pixel and its clip test
	always_comb begin
		on_canvas = !walk_x_q[COORD_BITS-1] && !walk_y_q[COORD_BITS-1]
			&& (CMP_W'(walk_x_q) < CMP_W'(canvas.width))
			&& (CMP_W'(walk_y_q) < CMP_W'(canvas.height));
		cur.x    = PIX_BITS'(walk_x_q);
		cur.y    = PIX_BITS'(walk_y_q);
		cur.last = 1'b0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			cur.color[c] = OUT_COLOR_BITS'(color_at(line_q.col_start[c], line_q.col_neg[c],
				acc_q[c]));
			rsum[c]  = {1'b0, rem_q[c]} + {1'b0, line_q.inc_r[c]};
			rwrap[c] = (rsum[c] >= {1'b0, line_q.span});
		end
		err_pos = !err_q[ERR_W-1] && (err_q != '0);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!queue_empty) state_nxt = B_WALK;
			end
			B_WALK: begin
				if (go && walk_end) state_nxt = B_FLUSH;
			end
			B_FLUSH: begin
				if (!pend_v_q || room) state_nxt = B_IDLE;
			end
			default: state_nxt = B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		room     = !out_valid_q || !out_stall;
		hold     = on_canvas && pend_v_q && !room;
		go       = !hold;
		walk_end = (on_canvas && (cnt_q == CNT_W'(MAX_RESULTS - 1))) || (steps_q == '0);
		pop      = (state_q == B_IDLE) && !queue_empty;
		take_pix = (state_q == B_WALK) && go && on_canvas;
		advance  = (state_q == B_WALK) && go && !walk_end;
		out_load = (take_pix && pend_v_q) || ((state_q == B_FLUSH) && pend_v_q && room);
		out_valid = out_valid_q;
		out_pixel = out_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_nxt;
			if (pop) cnt_q <= '0;
			else if (take_pix) cnt_q <= cnt_q + 1'b1;
			if (take_pix) pend_v_q <= 1'b1;
			else if (out_load) pend_v_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			line_q   <= queue_data;
			walk_x_q <= queue_data.x0;
			walk_y_q <= queue_data.y0;
			err_q    <= queue_data.err_init;
			steps_q  <= queue_data.span;
			acc_q    <= '0;
			rem_q    <= '0;
		end else if (advance) begin
			err_q   <= err_q + (err_pos ? line_q.two_diff : line_q.two_minor);
			steps_q <= steps_q - 1'b1;
			if (line_q.x_major || err_pos)
				walk_x_q <= line_q.neg_x ? (walk_x_q - 1'b1) : (walk_x_q + 1'b1);
			if (!line_q.x_major || err_pos)
				walk_y_q <= line_q.neg_y ? (walk_y_q - 1'b1) : (walk_y_q + 1'b1);
			for (int c = 0; c < NUM_CHAN; c++) begin
				if (rwrap[c]) begin
					acc_q[c] <= acc_q[c] + line_q.inc_q[c] + 1'b1;
					rem_q[c] <= COORD_BITS'(rsum[c] - {1'b0, line_q.span});
				end else begin
					acc_q[c] <= acc_q[c] + line_q.inc_q[c];
					rem_q[c] <= rsum[c][COORD_BITS-1:0];
				end
			end
		end
		// one pixel held back so the final kept one can be marked
		if (take_pix) pend_q <= cur;
		if (out_load) begin
			out_q.x     <= pend_q.x;
			out_q.y     <= pend_q.y;
			out_q.color <= pend_q.color;
			out_q.last  <= (state_q == B_FLUSH);
		end
	end

endmodule

`default_nettype wire
